### rtl/ac_pkg.sv
// shared constants, types and helpers for the multi-pattern match counter
`timescale 1ns / 1ps

package ac_pkg;

   localparam int NODES     = 4096;
   localparam int ALPHABET  = 27;
   localparam int NODE_W    = $clog2(NODES);
   localparam int USED_W    = $clog2(NODES + 1);
   localparam int SYM_W     = 5;
   localparam int COL_W     = $clog2(ALPHABET);
   localparam int CADDR_W   = $clog2(NODES * ALPHABET);
   localparam int CNT_W     = 12;
   localparam int TOT_W     = 16;
   localparam int OP_W      = 2;

   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
   localparam logic [OP_W-1:0] OP_PATTERN = 2'd1;
   localparam logic [OP_W-1:0] OP_BUILD   = 2'd2;
   localparam logic [OP_W-1:0] OP_TEXT    = 2'd3;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
   localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

   // engine status toward the output register
   typedef struct packed {
      logic             idle;
      logic             push;
      logic [TOT_W-1:0] match_count;
      logic             store_full;
   } ac_status_type;

   // first child-table address of a node row
   function automatic logic [CADDR_W-1:0] row_base(input logic [NODE_W-1:0] n);
      row_base = CADDR_W'(n) * CADDR_W'(ALPHABET);
   endfunction

endpackage

### rtl/ac_ram.sv
// generic one-write one-read synchronous ram, registered read data
`timescale 1ns / 1ps

module ac_ram #(
   parameter int DEPTH = 4096,
   parameter int WIDTH = 12
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule

### rtl/ac_engine.sv
// trie/automaton sequencer with node, link, count, mark and queue memories
`timescale 1ns / 1ps

module ac_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_valid,
   input  logic [ac_pkg::OP_W-1:0]     opcode,
   input  logic [ac_pkg::SYM_W-1:0]    symbol,
   input  logic                        last,
   input  logic                        out_free,
   output ac_pkg::ac_status_type       status
);

   localparam int ST_W = 5;
   localparam logic [ST_W-1:0] ST_IDLE     = 5'd0;
   localparam logic [ST_W-1:0] ST_DECODE   = 5'd1;
   localparam logic [ST_W-1:0] ST_ZERO     = 5'd2;
   localparam logic [ST_W-1:0] ST_PAT_RD   = 5'd3;
   localparam logic [ST_W-1:0] ST_PAT_WT   = 5'd4;
   localparam logic [ST_W-1:0] ST_PAT_LAST = 5'd5;
   localparam logic [ST_W-1:0] ST_PAT_END  = 5'd6;
   localparam logic [ST_W-1:0] ST_TXT_RD   = 5'd7;
   localparam logic [ST_W-1:0] ST_TXT_WT   = 5'd8;
   localparam logic [ST_W-1:0] ST_TXT_CHK  = 5'd9;
   localparam logic [ST_W-1:0] ST_BR_RD    = 5'd10;
   localparam logic [ST_W-1:0] ST_BR_WT    = 5'd11;
   localparam logic [ST_W-1:0] ST_BQ_POP   = 5'd12;
   localparam logic [ST_W-1:0] ST_BQ_U     = 5'd13;
   localparam logic [ST_W-1:0] ST_BQ_F     = 5'd14;
   localparam logic [ST_W-1:0] ST_BC_RV    = 5'd15;
   localparam logic [ST_W-1:0] ST_BC_RF    = 5'd16;
   localparam logic [ST_W-1:0] ST_BC_W     = 5'd17;
   localparam logic [ST_W-1:0] ST_MCLR     = 5'd18;
   localparam logic [ST_W-1:0] ST_FINISH   = 5'd19;

   localparam int NW = ac_pkg::NODE_W;
   localparam int UW = ac_pkg::USED_W;
   localparam int CW = ac_pkg::CADDR_W;
   localparam logic [ac_pkg::COL_W-1:0] COL_LAST = ac_pkg::COL_W'(ac_pkg::ALPHABET - 1);

   logic [ST_W-1:0]               state_ff, state_in, ret_ff, ret_in;
   logic [ac_pkg::OP_W-1:0]       op_ff, op_in;
   logic [ac_pkg::SYM_W-1:0]      sym_ff, sym_in;
   logic                          last_ff, last_in;
   logic [UW-1:0]                 used_ff, used_in;
   logic [NW-1:0]                 ins_ff, ins_in, scan_ff, scan_in;
   logic [ac_pkg::TOT_W-1:0]      total_ff, total_in;
   logic                          full_ff, full_in, built_ff, built_in;
   logic                          dropped_ff, dropped_in;
   logic [NW-1:0]                 zn_ff, zn_in, t_ff, t_in, v_ff, v_in;
   logic [CW-1:0]                 base_ff, base_in, fbase_ff, fbase_in;
   logic [ac_pkg::COL_W-1:0]      col_ff, col_in;
   logic [UW-1:0]                 head_ff, head_in, tail_ff, tail_in, k_ff, k_in;

   // memory ports
   logic          c_we, f_we, e_we, m_we, q_we;
   logic [CW-1:0] c_waddr, c_raddr;
   logic [NW-1:0] c_wd, c_rd, f_wd, f_rd, q_wd, q_rd;
   logic [NW-1:0] f_waddr, f_raddr, e_waddr, e_raddr, m_waddr, m_raddr;
   logic [NW-1:0] q_waddr, q_raddr;
   logic [ac_pkg::CNT_W-1:0] e_wd, e_rd;
   logic          m_wd, m_rd;

   logic                       sym_ok;
   logic [CW-1:0]              caddr_u, caddr_f;
   logic [ac_pkg::TOT_W:0]     sum;

   assign sym_ok  = sym_ff < ac_pkg::SYM_W'(ac_pkg::ALPHABET);
   assign caddr_u = base_ff + CW'(col_ff);
   assign caddr_f = fbase_ff + CW'(col_ff);
   assign sum     = {1'b0, total_ff} + (ac_pkg::TOT_W + 1)'(e_rd);

   ac_ram #(.DEPTH(ac_pkg::NODES * ac_pkg::ALPHABET), .WIDTH(NW)) u_child (
      .clock(clock), .we(c_we), .waddr(c_waddr), .wdata(c_wd), .raddr(c_raddr), .rdata(c_rd));
   ac_ram #(.DEPTH(ac_pkg::NODES), .WIDTH(NW)) u_fail (
      .clock(clock), .we(f_we), .waddr(f_waddr), .wdata(f_wd), .raddr(f_raddr), .rdata(f_rd));
   ac_ram #(.DEPTH(ac_pkg::NODES), .WIDTH(ac_pkg::CNT_W)) u_end (
      .clock(clock), .we(e_we), .waddr(e_waddr), .wdata(e_wd), .raddr(e_raddr), .rdata(e_rd));
   ac_ram #(.DEPTH(ac_pkg::NODES), .WIDTH(1)) u_mark (
      .clock(clock), .we(m_we), .waddr(m_waddr), .wdata(m_wd), .raddr(m_raddr), .rdata(m_rd));
   ac_ram #(.DEPTH(ac_pkg::NODES), .WIDTH(NW)) u_queue (
      .clock(clock), .we(q_we), .waddr(q_waddr), .wdata(q_wd), .raddr(q_raddr), .rdata(q_rd));

   // sequencer
   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;
      op_in = op_ff;  sym_in = sym_ff;  last_in = last_ff;
      used_in = used_ff;  ins_in = ins_ff;  scan_in = scan_ff;
      total_in = total_ff;  full_in = full_ff;  built_in = built_ff;
      dropped_in = dropped_ff;  zn_in = zn_ff;  t_in = t_ff;  v_in = v_ff;
      base_in = base_ff;  fbase_in = fbase_ff;  col_in = col_ff;
      head_in = head_ff;  tail_in = tail_ff;  k_in = k_ff;
      c_we = 1'b0;  c_waddr = caddr_u;  c_raddr = caddr_u;  c_wd = '0;
      f_we = 1'b0;  f_waddr = zn_ff;  f_raddr = t_ff;  f_wd = '0;
      e_we = 1'b0;  e_waddr = zn_ff;  e_raddr = ins_ff;  e_wd = '0;
      m_we = 1'b0;  m_waddr = zn_ff;  m_raddr = t_ff;  m_wd = 1'b0;
      q_we = 1'b0;  q_waddr = tail_ff[NW-1:0];  q_raddr = head_ff[NW-1:0];  q_wd = v_ff;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               op_in = opcode;  sym_in = symbol;  last_in = last;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (op_ff)
               ac_pkg::OP_CLEAR: begin
                  used_in = UW'(1);  ins_in = '0;  scan_in = '0;  total_in = '0;
                  full_in = 1'b0;  built_in = 1'b0;  dropped_in = 1'b0;
                  zn_in = '0;  base_in = '0;  col_in = '0;
                  ret_in = ST_FINISH;  state_in = ST_ZERO;
               end
               ac_pkg::OP_PATTERN: begin
                  if (built_ff || !sym_ok) begin
                     state_in = ST_FINISH;
                  end else if (dropped_ff) begin
                     state_in = ST_PAT_LAST;
                  end else begin
                     base_in = ac_pkg::row_base(ins_ff);
                     col_in = ac_pkg::COL_W'(sym_ff);
                     state_in = ST_PAT_RD;
                  end
               end
               ac_pkg::OP_BUILD: begin
                  k_in = '0;
                  if (built_ff) begin
                     state_in = ST_MCLR;
                  end else begin
                     base_in = '0;  col_in = '0;  head_in = '0;  tail_in = '0;
                     state_in = ST_BR_RD;
                  end
               end
               ac_pkg::OP_TEXT: begin
                  if (!sym_ok) begin
                     scan_in = '0;
                     state_in = ST_FINISH;
                  end else begin
                     base_in = ac_pkg::row_base(scan_ff);
                     col_in = ac_pkg::COL_W'(sym_ff);
                     state_in = ST_TXT_RD;
                  end
               end
               default: state_in = ST_FINISH;
            endcase
         end
         // zero a fresh node row, plus its link, count and mark
         ST_ZERO: begin
            c_we = 1'b1;
            if (col_ff == '0) begin
               f_we = 1'b1;  e_we = 1'b1;  m_we = 1'b1;
            end
            if (col_ff == COL_LAST) begin
               state_in = ret_ff;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_PAT_RD: state_in = ST_PAT_WT;
         // follow the edge, allocate a node, or drop the pattern when the store is full
         ST_PAT_WT: begin
            if (c_rd != '0) begin
               ins_in = c_rd;
               state_in = ST_PAT_LAST;
            end else if (used_ff < UW'(ac_pkg::NODES)) begin
               c_we = 1'b1;
               c_wd = used_ff[NW-1:0];
               ins_in = used_ff[NW-1:0];
               zn_in = used_ff[NW-1:0];
               used_in = used_ff + 1'b1;
               base_in = ac_pkg::row_base(used_ff[NW-1:0]);
               col_in = '0;
               ret_in = ST_PAT_LAST;
               state_in = ST_ZERO;
            end else begin
               full_in = 1'b1;
               dropped_in = 1'b1;
               state_in = ST_PAT_LAST;
            end
         end
         ST_PAT_LAST: begin
            if (!last_ff) begin
               state_in = ST_FINISH;
            end else if (dropped_ff) begin
               ins_in = '0;  dropped_in = 1'b0;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_PAT_END;
            end
         end
         // bump the pattern count at the end node
         ST_PAT_END: begin
            e_we = 1'b1;
            e_waddr = ins_ff;
            e_wd = (e_rd == ac_pkg::CNT_MAX) ? e_rd : e_rd + 1'b1;
            ins_in = '0;
            state_in = ST_FINISH;
         end
         ST_TXT_RD: state_in = ST_TXT_WT;
         ST_TXT_WT: begin
            scan_in = c_rd;
            t_in = c_rd;
            f_raddr = c_rd;  e_raddr = c_rd;  m_raddr = c_rd;
            state_in = (c_rd == '0) ? ST_FINISH : ST_TXT_CHK;
         end
         // one failure-chain node per cycle
         ST_TXT_CHK: begin
            if (m_rd) begin
               state_in = ST_FINISH;
            end else begin
               total_in = sum[ac_pkg::TOT_W] ? ac_pkg::TOT_MAX : sum[ac_pkg::TOT_W-1:0];
               m_we = 1'b1;  m_waddr = t_ff;  m_wd = 1'b1;
               t_in = f_rd;
               f_raddr = f_rd;  e_raddr = f_rd;  m_raddr = f_rd;
               if (f_rd == '0) begin
                  state_in = ST_FINISH;
               end
            end
         end
         // queue the root children
         ST_BR_RD: state_in = ST_BR_WT;
         ST_BR_WT: begin
            if (c_rd != '0) begin
               q_we = 1'b1;  q_wd = c_rd;
               tail_in = tail_ff + 1'b1;
            end
            if (col_ff == COL_LAST) begin
               state_in = ST_BQ_POP;
            end else begin
               col_in = col_ff + 1'b1;
               state_in = ST_BR_RD;
            end
         end
         ST_BQ_POP: begin
            if (head_ff == tail_ff) begin
               state_in = ST_MCLR;
            end else begin
               head_in = head_ff + 1'b1;
               state_in = ST_BQ_U;
            end
         end
         ST_BQ_U: begin
            base_in = ac_pkg::row_base(q_rd);
            f_raddr = q_rd;
            state_in = ST_BQ_F;
         end
         ST_BQ_F: begin
            fbase_in = ac_pkg::row_base(f_rd);
            col_in = '0;
            state_in = ST_BC_RV;
         end
         ST_BC_RV: state_in = ST_BC_RF;
         ST_BC_RF: begin
            v_in = c_rd;
            c_raddr = caddr_f;
            state_in = ST_BC_W;
         end
         // child gets a link and a queue slot, missing edge takes the fail row's
         ST_BC_W: begin
            if (v_ff != '0) begin
               q_we = 1'b1;
               tail_in = tail_ff + 1'b1;
               f_we = 1'b1;  f_waddr = v_ff;  f_wd = c_rd;
            end else begin
               c_we = 1'b1;  c_wd = c_rd;
            end
            if (col_ff == COL_LAST) begin
               state_in = ST_BQ_POP;
            end else begin
               col_in = col_ff + 1'b1;
               state_in = ST_BC_RV;
            end
         end
         // sweep marks of all used nodes
         ST_MCLR: begin
            m_we = 1'b1;  m_waddr = k_ff[NW-1:0];
            if (k_ff + 1'b1 == used_ff) begin
               total_in = '0;  scan_in = '0;  ins_in = '0;
               dropped_in = 1'b0;  built_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ZERO;  ret_ff <= ST_IDLE;
         used_ff <= UW'(1);  ins_ff <= '0;  scan_ff <= '0;  total_ff <= '0;
         full_ff <= 1'b0;  built_ff <= 1'b0;  dropped_ff <= 1'b0;
         zn_ff <= '0;  base_ff <= '0;  col_ff <= '0;
      end else begin
         state_ff <= state_in;  ret_ff <= ret_in;
         used_ff <= used_in;  ins_ff <= ins_in;  scan_ff <= scan_in;  total_ff <= total_in;
         full_ff <= full_in;  built_ff <= built_in;  dropped_ff <= dropped_in;
         zn_ff <= zn_in;  base_ff <= base_in;  col_ff <= col_in;
      end
   end

   // item and walk registers
   always_ff @(posedge clock) begin
      op_ff <= op_in;  sym_ff <= sym_in;  last_ff <= last_in;
      t_ff <= t_in;  v_ff <= v_in;  fbase_ff <= fbase_in;
      head_ff <= head_in;  tail_ff <= tail_in;  k_ff <= k_in;
   end

   assign status.idle        = state_ff == ST_IDLE;
   assign status.push        = (state_ff == ST_FINISH) && out_free;
   assign status.match_count = total_ff;
   assign status.store_full  = full_ff;

endmodule

### rtl/multi_pattern_match_counter_top.sv
// top level: request handshake, engine and result register
`timescale 1ns / 1ps
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid req_stall req_opcode          | in
//          | req_symbol req_last                     |
//  rsp     | rsp_valid rsp_stall rsp_match_count     | out
//          | rsp_store_full                          |
//
//  one item at a time through the sequencer, one write and one read port per memory
//  clear and new nodes: zero a child row slot by slot; text: follow the edge, then check
//  chain nodes one by one; build: queue the root children, then per queued node read its
//  link and fill its row slot by slot, then clear the mark of every used node
//  reset zeroes the root row with req_stall high
//  a finished beat waits in the result register; the next item may enter meanwhile

module multi_pattern_match_counter_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ac_pkg::OP_W-1:0]         req_opcode,
   input  logic [ac_pkg::SYM_W-1:0]        req_symbol,
   input  logic                            req_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ac_pkg::TOT_W-1:0]        rsp_match_count,
   output logic                            rsp_store_full
);

   ac_pkg::ac_status_type status;
   logic rsp_valid_ff, rsp_valid_in;
   logic [ac_pkg::TOT_W-1:0] count_ff;
   logic full_ff;
   logic out_free;

   assign req_stall = !status.idle;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   ac_engine u_engine (
      .clock(clock),
      .reset(reset),
      .item_valid(req_valid && !req_stall),
      .opcode(req_opcode),
      .symbol(req_symbol),
      .last(req_last),
      .out_free(out_free),
      .status(status)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (status.push) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (status.push) begin
         count_ff <= status.match_count;
         full_ff  <= status.store_full;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_match_count = count_ff;
   assign rsp_store_full  = full_ff;

   // a beat is never pushed over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      status.push |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten");

   // an idle engine has nothing to deliver
   assert property (@(posedge clock) disable iff (reset)
      !req_stall |-> !status.push)
      else $error("push while idle");

   // a pushed beat shows up on the port
   assert property (@(posedge clock) disable iff (reset)
      status.push |=> rsp_valid)
      else $error("pushed beat lost");

endmodule

### test/match_checker.sv
// checker: predicts the automaton results and compares every result beat
`timescale 1ns / 1ps

module match_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [ac_pkg::OP_W-1:0]  req_opcode,
   input  logic [ac_pkg::SYM_W-1:0] req_symbol,
   input  logic                     req_last,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic [ac_pkg::TOT_W-1:0] rsp_match_count,
   input  logic                     rsp_store_full,
   output int                       errors,
   output int                       pending
);

   typedef struct {
      logic [ac_pkg::TOT_W-1:0] count;
      logic                     full;
   } totals_type;

   // own copy of the trie and the scan state
   logic [ac_pkg::NODE_W-1:0] goto_tab [ac_pkg::NODES*ac_pkg::ALPHABET];
   logic [ac_pkg::NODE_W-1:0] fail_tab [ac_pkg::NODES];
   logic [ac_pkg::CNT_W-1:0]  hits_tab [ac_pkg::NODES];
   logic [ac_pkg::NODE_W-1:0] bfs_fifo [ac_pkg::NODES];
   bit                        seen_tab [ac_pkg::NODES];
   int                        node_cnt;
   logic [ac_pkg::NODE_W-1:0] ins_node, scan_node;
   int                        running_total;
   bit                        full_seen, frozen, skip_pattern;

   totals_type totals_q[$];

   task automatic wipe_trie();
      for (int s = 0; s < ac_pkg::ALPHABET; s++) goto_tab[s] = '0;
      fail_tab[0] = '0;
      hits_tab[0] = '0;
      seen_tab[0] = 0;
      node_cnt = 1;
      ins_node = '0;
      scan_node = '0;
      running_total = 0;
      full_seen = 0;
      frozen = 0;
      skip_pattern = 0;
   endtask

   task automatic link_trie();
      int head, tail;
      logic [ac_pkg::NODE_W-1:0] u, f, v, fv;
      head = 0;
      tail = 0;
      for (int s = 0; s < ac_pkg::ALPHABET; s++) begin
         v = goto_tab[s];
         if (v != 0 && tail < ac_pkg::NODES) begin
            fail_tab[v] = '0;
            bfs_fifo[tail] = v;
            tail++;
         end
      end
      while (head < tail) begin
         u = bfs_fifo[head];
         head++;
         f = fail_tab[u];
         for (int s = 0; s < ac_pkg::ALPHABET; s++) begin
            v = goto_tab[u*ac_pkg::ALPHABET+s];
            fv = goto_tab[f*ac_pkg::ALPHABET+s];
            if (v != 0) begin
               if (tail < ac_pkg::NODES) begin
                  bfs_fifo[tail] = v;
                  tail++;
               end
               fail_tab[v] = fv;
            end else begin
               goto_tab[u*ac_pkg::ALPHABET+s] = fv;
            end
         end
      end
   endtask

   task automatic add_pattern_symbol(input int sym, input bit fin);
      logic [ac_pkg::NODE_W-1:0] c;
      if (!skip_pattern) begin
         c = goto_tab[ins_node*ac_pkg::ALPHABET+sym];
         if (c == 0) begin
            if (node_cnt < ac_pkg::NODES) begin
               c = ac_pkg::NODE_W'(node_cnt);
               node_cnt++;
               for (int s = 0; s < ac_pkg::ALPHABET; s++)
                  goto_tab[c*ac_pkg::ALPHABET+s] = '0;
               fail_tab[c] = '0;
               hits_tab[c] = '0;
               seen_tab[c] = 0;
               goto_tab[ins_node*ac_pkg::ALPHABET+sym] = c;
            end else begin
               full_seen = 1;
               skip_pattern = 1;
            end
         end
         if (!skip_pattern) ins_node = c;
      end
      if (fin) begin
         if (!skip_pattern && hits_tab[ins_node] != ac_pkg::CNT_MAX)
            hits_tab[ins_node] = hits_tab[ins_node] + 1'b1;
         ins_node = '0;
         skip_pattern = 0;
      end
   endtask

   task automatic scan_text_symbol(input int sym);
      logic [ac_pkg::NODE_W-1:0] t;
      int steps;
      scan_node = goto_tab[scan_node*ac_pkg::ALPHABET+sym];
      t = scan_node;
      steps = 0;
      while (steps < ac_pkg::NODES && t != 0 && !seen_tab[t]) begin
         running_total += hits_tab[t];
         if (running_total > int'(ac_pkg::TOT_MAX)) running_total = int'(ac_pkg::TOT_MAX);
         seen_tab[t] = 1;
         t = fail_tab[t];
         steps++;
      end
   endtask

   // one accepted request beat yields one expected result
   task automatic predict_item(input logic [ac_pkg::OP_W-1:0] op, input int sym,
                               input bit fin);
      totals_type r;
      case (op)
         ac_pkg::OP_CLEAR: wipe_trie();
         ac_pkg::OP_PATTERN: begin
            if (!frozen && sym < ac_pkg::ALPHABET) add_pattern_symbol(sym, fin);
         end
         ac_pkg::OP_BUILD: begin
            if (!frozen) begin
               link_trie();
               frozen = 1;
            end
            for (int n = 0; n < ac_pkg::NODES; n++) seen_tab[n] = 0;
            running_total = 0;
            scan_node = '0;
            ins_node = '0;
            skip_pattern = 0;
         end
         default: begin
            if (sym < ac_pkg::ALPHABET) scan_text_symbol(sym);
            else scan_node = '0;
         end
      endcase
      r.count = ac_pkg::TOT_W'(running_total);
      r.full = full_seen;
      totals_q.push_back(r);
   endtask

   initial begin
      errors = 0;
      pending = 0;
      wipe_trie();
   end

   // watch both channels
   always @(posedge clock) begin
      totals_type want;
      if (reset) begin
         wipe_trie();
         totals_q.delete();
      end else begin
         if (req_valid && !req_stall)
            predict_item(req_opcode, int'(req_symbol), req_last);
         if (rsp_valid && !rsp_stall) begin
            if (totals_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat: expected none, actual count %0d full %0b",
                        $time, rsp_match_count, rsp_store_full);
            end else begin
               want = totals_q.pop_front();
               if (rsp_match_count !== want.count) begin
                  errors++;
                  $display("%0t: match_count mismatch: expected %0d, actual %0d",
                           $time, want.count, rsp_match_count);
               end
               if (rsp_store_full !== want.full) begin
                  errors++;
                  $display("%0t: store_full mismatch: expected %0b, actual %0b",
                           $time, want.full, rsp_store_full);
               end
            end
         end
      end
      pending = totals_q.size();
   end

endmodule

### test/tb_top.sv
// testbench top: clock, reset, request stimulus and the final verdict
`timescale 1ns / 1ps

module tb_top;

   localparam int CYCLE_LIMIT = 1000000;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_stall;
   logic [ac_pkg::OP_W-1:0]  req_opcode = ac_pkg::OP_CLEAR;
   logic [ac_pkg::SYM_W-1:0] req_symbol = '0;
   logic                     req_last = 0;
   logic                     rsp_valid;
   logic                     rsp_stall = 0;
   logic [ac_pkg::TOT_W-1:0] rsp_match_count;
   logic                     rsp_store_full;
   int                       errors, pending;
   int                       cycles = 0;
   int                       items = 0;
   bit                       quiet = 0;

   always #5 clock = ~clock;

   multi_pattern_match_counter_top dut (.*);

   match_checker chk (.*);

   // receiver stalls at random outside the quiet stretch
   always @(posedge clock)
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < 21);

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // drive one request beat and wait for it to be taken
   task automatic send(input logic [ac_pkg::OP_W-1:0] op, input int sym, input bit fin);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_symbol <= ac_pkg::SYM_W'(sym);
      req_last   <= fin;
      do @(posedge clock); while (req_stall);
      items++;
      if (!quiet && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
   endtask

   task automatic send_word(input int len, input int span);
      for (int i = 0; i < len; i++)
         send(ac_pkg::OP_PATTERN, $urandom_range(span - 1), i == len - 1);
   endtask

   initial begin
      int span, n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: small dictionary, extremes and odd items
      send(ac_pkg::OP_CLEAR, 0, 0);
      send(ac_pkg::OP_PATTERN, 0, 1);                 // a
      send(ac_pkg::OP_PATTERN, 0, 0);
      send(ac_pkg::OP_PATTERN, 1, 1);                 // ab
      send(ac_pkg::OP_PATTERN, 26, 1);                // z
      send(ac_pkg::OP_PATTERN, 31, 1);                // out of range, ignored
      send(ac_pkg::OP_PATTERN, 1, 1);
      send(ac_pkg::OP_PATTERN, 1, 1);                 // b twice
      send(ac_pkg::OP_TEXT, 0, 0);                    // text before build
      send(ac_pkg::OP_TEXT, 1, 0);
      send(ac_pkg::OP_BUILD, 0, 0);
      send(ac_pkg::OP_TEXT, 0, 0);
      send(ac_pkg::OP_TEXT, 1, 1);
      send(ac_pkg::OP_TEXT, 26, 0);
      send(ac_pkg::OP_TEXT, 31, 0);                   // out of range resets scan
      send(ac_pkg::OP_TEXT, 1, 0);
      send(ac_pkg::OP_PATTERN, 2, 1);                 // frozen trie, ignored
      send(ac_pkg::OP_BUILD, 0, 0);                   // rebuild keeps links
      send(ac_pkg::OP_TEXT, 0, 0);
      send(ac_pkg::OP_TEXT, 1, 0);
      send(ac_pkg::OP_CLEAR, 0, 0);

      // random epochs: dictionary, build, text
      while (items < 1000) begin
         quiet = (items > 400 && items < 550);
         send(ac_pkg::OP_CLEAR, 0, 0);
         span = $urandom_range(99) < 80 ? $urandom_range(4, 2) : ac_pkg::ALPHABET;
         n = $urandom_range(5, 1);
         for (int p = 0; p < n; p++) begin
            if ($urandom_range(9) == 0)
               send(ac_pkg::OP_PATTERN, $urandom_range(31, ac_pkg::ALPHABET),
                    $urandom_range(1));
            send_word($urandom_range(4, 1), span);
         end
         if ($urandom_range(9) < 2) send(ac_pkg::OP_PATTERN, $urandom_range(span - 1), 0);
         if ($urandom_range(9) == 0)
            for (int i = 0; i < 6; i++) send(ac_pkg::OP_TEXT, $urandom_range(span - 1), 0);
         send(ac_pkg::OP_BUILD, 0, 0);
         for (int i = 0; i < $urandom_range(60, 20); i++) begin
            case ($urandom_range(19))
               0: send(ac_pkg::OP_TEXT, $urandom_range(31, ac_pkg::ALPHABET),
                       $urandom_range(1));
               1: send(ac_pkg::OP_PATTERN, $urandom_range(31), $urandom_range(1));
               2: send(ac_pkg::OP_BUILD, $urandom_range(31), $urandom_range(1));
               default: send(ac_pkg::OP_TEXT, $urandom_range(span - 1), $urandom_range(1));
            endcase
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
